[sv/tbn_pkg.sv]
// ----------------------------------------------------------------------------
// tbn_pkg
// Shared widths, constants and the sequencer state type of the triangle
// tangent/binormal core.
// ----------------------------------------------------------------------------
package tbn_pkg;

  localparam int OUT_FRAC_BITS = 14;

  localparam int IDX_W  = 16;
  localparam int POS_W  = 32;
  localparam int TEX_W  = 24;
  localparam int OUT_W  = 16;

  localparam int EDGE_W = POS_W + 1;            // position difference
  localparam int DUV_W  = TEX_W + 1;            // texcoord difference
  localparam int MUL_W  = 33;                   // shared multiplier operand
  localparam int PROD_W = 2 * MUL_W;
  localparam int DET_W  = 2 * DUV_W + 1;
  localparam int VEC_W  = DUV_W + EDGE_W + 1;   // raw tangent/binormal component
  localparam int MAG_W  = VEC_W;
  localparam int NRM_W  = 30;                   // magnitude after range reduction
  localparam int SQ_W   = 2 * NRM_W;
  localparam int SUM_W  = SQ_W + 2;
  localparam int ACC_W  = 2 * OUT_FRAC_BITS + SUM_W + 4;
  localparam int SHL_W  = 2 * OUT_FRAC_BITS + 2;
  localparam int Y_W    = OUT_FRAC_BITS + 2;
  localparam int RND_W  = OUT_FRAC_BITS + 1;
  localparam int BIT_W  = $clog2(Y_W);
  localparam int NUM_PROD = 14;
  localparam int STEP_W = $clog2(NUM_PROD + 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_VLOAD,
    ST_VMAX,
    ST_SHIFT,
    ST_SQ,
    ST_SRCH,
    ST_OUT
  } state_t;

endpackage

[sv/tbn_mul.sv]
// ----------------------------------------------------------------------------
// tbn_mul
// Shared signed multiplier with a registered product.
// ----------------------------------------------------------------------------
module tbn_mul (
  input  logic                               clk,
  input  logic signed [tbn_pkg::MUL_W-1:0]   a,
  input  logic signed [tbn_pkg::MUL_W-1:0]   b,
  output logic signed [tbn_pkg::PROD_W-1:0]  prod
);
  import tbn_pkg::*;

  logic signed [PROD_W-1:0] prod_r;

  always_ff @(posedge clk) begin
    prod_r <= PROD_W'(a) * PROD_W'(b);
  end

  assign prod = prod_r;

endmodule

[sv/tbn_isqrt.sv]
// ----------------------------------------------------------------------------
// tbn_isqrt
// Bit-serial search for the largest y with y*y*S <= a2 << (2F+2).
// Keeps y*y*S and y*S incrementally, so each step is shifts and adds only.
// ----------------------------------------------------------------------------
module tbn_isqrt (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  input  logic [tbn_pkg::SUM_W-1:0]      s,
  input  logic [tbn_pkg::SQ_W-1:0]       a2,
  output logic                           done,
  output logic [tbn_pkg::Y_W-1:0]        y
);
  import tbn_pkg::*;

  logic              busy_r;
  logic              done_r;
  logic [BIT_W-1:0]  b_r;
  logic [Y_W-1:0]    y_r;
  logic [ACC_W-1:0]  p_r;
  logic [ACC_W-1:0]  qs_r;   // y*S << (b+1)
  logic [ACC_W-1:0]  ss_r;   // S << 2b
  logic [ACC_W-1:0]  t_r;
  logic [ACC_W+1:0]  pc;
  logic              take;
  logic [ACC_W-1:0]  qs_upd;

  assign pc     = (ACC_W+2)'(p_r) + (ACC_W+2)'(qs_r) + (ACC_W+2)'(ss_r);
  assign take   = pc <= (ACC_W+2)'(t_r);
  assign qs_upd = take ? (qs_r + (ss_r << 1)) : qs_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
      end else if (busy_r && b_r == '0) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      b_r  <= BIT_W'(Y_W - 1);
      y_r  <= '0;
      p_r  <= '0;
      qs_r <= '0;
      ss_r <= ACC_W'({s, {SHL_W{1'b0}}});
      t_r  <= ACC_W'({a2, {SHL_W{1'b0}}});
    end else if (busy_r) begin
      if (take) begin
        p_r      <= pc[ACC_W-1:0];
        y_r[b_r] <= 1'b1;
      end
      qs_r <= qs_upd >> 1;
      ss_r <= ss_r >> 2;
      b_r  <= b_r - 1'b1;
    end
  end

  assign done = done_r;
  assign y    = y_r;

endmodule

[sv/triangle_tangent_binormal_core.sv]
// ----------------------------------------------------------------------------
// triangle_tangent_binormal_core
// Collects three triangle corners and returns one unit tangent/binormal frame
// per corner, computed on a shared multiplier and a bit-serial search unit.
// ----------------------------------------------------------------------------
//  channel  signals                          direction
//  in       in_valid/in_ready + corner       into core
//  out      out_valid/out_ready + frame      out of core
//
//  Corners one and two are taken as soon as they are valid. The third corner
//  starts the multiplier phase, then per vector a setup, a range shift,
//  squaring and a search for each of its three components. The search unit
//  finds one result bit per cycle.
//  in_ready is low from the third corner until the third result is taken.
//  Reset is synchronous, active low; out_ready may stall each result freely.
// ----------------------------------------------------------------------------
module triangle_tangent_binormal_core (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [tbn_pkg::IDX_W-1:0]          in_vertex_index,
  input  logic signed [tbn_pkg::POS_W-1:0]   in_pos_x,
  input  logic signed [tbn_pkg::POS_W-1:0]   in_pos_y,
  input  logic signed [tbn_pkg::POS_W-1:0]   in_pos_z,
  input  logic signed [tbn_pkg::TEX_W-1:0]   in_tex_u,
  input  logic signed [tbn_pkg::TEX_W-1:0]   in_tex_v,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [tbn_pkg::IDX_W-1:0]          out_vertex_index,
  output logic signed [tbn_pkg::OUT_W-1:0]   out_tangent_x,
  output logic signed [tbn_pkg::OUT_W-1:0]   out_tangent_y,
  output logic signed [tbn_pkg::OUT_W-1:0]   out_tangent_z,
  output logic signed [tbn_pkg::OUT_W-1:0]   out_binormal_x,
  output logic signed [tbn_pkg::OUT_W-1:0]   out_binormal_y,
  output logic signed [tbn_pkg::OUT_W-1:0]   out_binormal_z,
  output logic                               out_degenerate,
  output logic                               out_last
);
  import tbn_pkg::*;

  state_t state_r, state_nxt;

  logic [1:0]               cnt_r;
  logic [STEP_W-1:0]        st_r;
  logic [STEP_W-1:0]        po;
  logic [1:0]               k_r;
  logic [1:0]               oc_r;
  logic                     vsel_r;
  logic                     go_r;
  logic                     degen_r;

  logic [IDX_W-1:0]         idx_r [3];
  logic signed [POS_W-1:0]  p0_r [3];
  logic signed [POS_W-1:0]  p1_r [3];
  logic signed [TEX_W-1:0]  t0_r [2];
  logic signed [TEX_W-1:0]  t1_r [2];
  logic signed [EDGE_W-1:0] e01_r [3];
  logic signed [EDGE_W-1:0] e02_r [3];
  logic signed [DUV_W-1:0]  d01_r [2];
  logic signed [DUV_W-1:0]  d02_r [2];
  logic signed [DET_W-1:0]  det_r;
  logic signed [VEC_W-1:0]  tg_r [3];
  logic signed [VEC_W-1:0]  bn_r [3];
  logic [MAG_W-1:0]         mag_r [3];
  logic                     neg_r [3];
  logic [MAG_W-1:0]         m_r;
  logic [SQ_W-1:0]          a2_r [3];
  logic [SUM_W-1:0]         s_r;
  logic [OUT_W-1:0]         tq_r [3];
  logic [OUT_W-1:0]         bq_r [3];

  logic signed [MUL_W-1:0]  mul_a, mul_b;
  logic signed [PROD_W-1:0] prod;
  logic signed [DET_W-1:0]  prod_det;
  logic signed [VEC_W-1:0]  prod_vec;
  logic [1:0]               pj;

  logic                     srch_start;
  logic                     srch_done;
  logic [Y_W-1:0]           srch_y;
  logic [RND_W-1:0]         rnd_mag;
  logic [31:0]              rnd_wide;
  logic [OUT_W-1:0]         rnd_out;

  logic                     in_acc, out_acc;
  logic                     shift_need;

  assign in_acc  = in_valid && in_ready;
  assign out_acc = out_valid && out_ready;
  assign shift_need = |m_r[MAG_W-1:NRM_W];

  // ---------------- shared multiplier operand select ----------------
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    if (state_r == ST_MUL) begin
      case (st_r)
        4'd0:  begin mul_a = MUL_W'(d01_r[0]); mul_b = MUL_W'(d02_r[1]); end
        4'd1:  begin mul_a = MUL_W'(d02_r[0]); mul_b = MUL_W'(d01_r[1]); end
        4'd2:  begin mul_a = MUL_W'(d02_r[1]); mul_b = MUL_W'(e01_r[0]); end
        4'd3:  begin mul_a = MUL_W'(d01_r[1]); mul_b = MUL_W'(e02_r[0]); end
        4'd4:  begin mul_a = MUL_W'(d02_r[1]); mul_b = MUL_W'(e01_r[1]); end
        4'd5:  begin mul_a = MUL_W'(d01_r[1]); mul_b = MUL_W'(e02_r[1]); end
        4'd6:  begin mul_a = MUL_W'(d02_r[1]); mul_b = MUL_W'(e01_r[2]); end
        4'd7:  begin mul_a = MUL_W'(d01_r[1]); mul_b = MUL_W'(e02_r[2]); end
        4'd8:  begin mul_a = MUL_W'(d01_r[0]); mul_b = MUL_W'(e02_r[0]); end
        4'd9:  begin mul_a = MUL_W'(d02_r[0]); mul_b = MUL_W'(e01_r[0]); end
        4'd10: begin mul_a = MUL_W'(d01_r[0]); mul_b = MUL_W'(e02_r[1]); end
        4'd11: begin mul_a = MUL_W'(d02_r[0]); mul_b = MUL_W'(e01_r[1]); end
        4'd12: begin mul_a = MUL_W'(d01_r[0]); mul_b = MUL_W'(e02_r[2]); end
        4'd13: begin mul_a = MUL_W'(d02_r[0]); mul_b = MUL_W'(e01_r[2]); end
        default: begin mul_a = '0; mul_b = '0; end
      endcase
    end else if (state_r == ST_SQ && st_r < 4'd3) begin
      mul_a = MUL_W'(mag_r[st_r[1:0]][NRM_W-1:0]);
      mul_b = MUL_W'(mag_r[st_r[1:0]][NRM_W-1:0]);
    end
  end

  tbn_mul u_mul (
    .clk  (clk),
    .a    (mul_a),
    .b    (mul_b),
    .prod (prod)
  );

  // op issued last cycle and its target component
  assign po       = st_r - 1'b1;
  assign pj       = (po < 4'd8) ? 2'((po - 4'd2) >> 1) : 2'((po - 4'd8) >> 1);
  assign prod_det = DET_W'(prod);
  assign prod_vec = VEC_W'(prod);

  // ---------------- search unit ----------------
  assign srch_start = (state_r == ST_SRCH) && go_r;

  tbn_isqrt u_isqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .start (srch_start),
    .s     (s_r),
    .a2    (a2_r[k_r]),
    .done  (srch_done),
    .y     (srch_y)
  );

  // round to nearest, ties away, then apply sign and wrap to the port width
  assign rnd_mag  = RND_W'((srch_y + 1'b1) >> 1);
  assign rnd_wide = neg_r[k_r] ? (32'd0 - 32'(rnd_mag)) : 32'(rnd_mag);
  assign rnd_out  = rnd_wide[OUT_W-1:0];

  // ---------------- sequencer ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    in_ready  = 1'b0;
    out_valid = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid && cnt_r == 2'd2) begin
          state_nxt = ST_MUL;
        end
      end
      ST_MUL: begin
        if (st_r == STEP_W'(NUM_PROD)) begin
          state_nxt = (det_r == '0) ? ST_OUT : ST_VLOAD;
        end
      end
      ST_VLOAD: state_nxt = ST_VMAX;
      ST_VMAX:  state_nxt = ST_SHIFT;
      ST_SHIFT: begin
        if (m_r == '0) begin
          state_nxt = vsel_r ? ST_OUT : ST_VLOAD;
        end else if (!shift_need) begin
          state_nxt = ST_SQ;
        end
      end
      ST_SQ: begin
        if (st_r == 4'd3) begin
          state_nxt = ST_SRCH;
        end
      end
      ST_SRCH: begin
        if (srch_done && k_r == 2'd2) begin
          state_nxt = vsel_r ? ST_OUT : ST_VLOAD;
        end
      end
      ST_OUT: begin
        out_valid = 1'b1;
        if (out_ready && oc_r == 2'd2) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // control counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      st_r  <= '0;
      k_r   <= '0;
      oc_r  <= '0;
      go_r  <= 1'b0;
    end else begin
      go_r <= 1'b0;
      case (state_r)
        ST_IDLE: begin
          if (in_acc) begin
            cnt_r <= (cnt_r == 2'd2) ? 2'd0 : cnt_r + 1'b1;
            st_r  <= '0;
          end
          oc_r <= '0;
        end
        ST_MUL: st_r <= st_r + 1'b1;
        ST_SHIFT: st_r <= '0;
        ST_SQ: begin
          st_r <= st_r + 1'b1;
          if (st_r == 4'd3) begin
            k_r  <= '0;
            go_r <= 1'b1;
          end
        end
        ST_SRCH: begin
          if (srch_done && k_r != 2'd2) begin
            k_r  <= k_r + 1'b1;
            go_r <= 1'b1;
          end
        end
        ST_OUT: begin
          if (out_ready) begin
            oc_r <= oc_r + 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (cnt_r == 2'd0) begin
            idx_r[0] <= in_vertex_index;
            p0_r[0]  <= in_pos_x;
            p0_r[1]  <= in_pos_y;
            p0_r[2]  <= in_pos_z;
            t0_r[0]  <= in_tex_u;
            t0_r[1]  <= in_tex_v;
          end else if (cnt_r == 2'd1) begin
            idx_r[1] <= in_vertex_index;
            p1_r[0]  <= in_pos_x;
            p1_r[1]  <= in_pos_y;
            p1_r[2]  <= in_pos_z;
            t1_r[0]  <= in_tex_u;
            t1_r[1]  <= in_tex_v;
          end else begin
            idx_r[2] <= in_vertex_index;
            for (int j = 0; j < 3; j++) begin
              e01_r[j] <= EDGE_W'(p1_r[j]) - EDGE_W'(p0_r[j]);
              tq_r[j]  <= '0;
              bq_r[j]  <= '0;
            end
            e02_r[0] <= EDGE_W'(in_pos_x) - EDGE_W'(p0_r[0]);
            e02_r[1] <= EDGE_W'(in_pos_y) - EDGE_W'(p0_r[1]);
            e02_r[2] <= EDGE_W'(in_pos_z) - EDGE_W'(p0_r[2]);
            d01_r[0] <= DUV_W'(t1_r[0]) - DUV_W'(t0_r[0]);
            d01_r[1] <= DUV_W'(t1_r[1]) - DUV_W'(t0_r[1]);
            d02_r[0] <= DUV_W'(in_tex_u) - DUV_W'(t0_r[0]);
            d02_r[1] <= DUV_W'(in_tex_v) - DUV_W'(t0_r[1]);
            degen_r  <= 1'b0;
            vsel_r   <= 1'b0;
          end
        end
      end
      ST_MUL: begin
        if (st_r != '0) begin
          if (po == 4'd0) begin
            det_r <= prod_det;
          end else if (po == 4'd1) begin
            det_r <= det_r - prod_det;
          end else if (po < 4'd8) begin
            tg_r[pj] <= po[0] ? (tg_r[pj] - prod_vec) : prod_vec;
          end else begin
            bn_r[pj] <= po[0] ? (bn_r[pj] - prod_vec) : prod_vec;
          end
        end
        if (st_r == STEP_W'(NUM_PROD) && det_r == '0) begin
          degen_r <= 1'b1;
        end
      end
      ST_VLOAD: begin
        for (int j = 0; j < 3; j++) begin
          if (vsel_r) begin
            mag_r[j] <= bn_r[j][VEC_W-1] ? MAG_W'(-bn_r[j]) : MAG_W'(bn_r[j]);
            neg_r[j] <= bn_r[j][VEC_W-1] ^ det_r[DET_W-1];
          end else begin
            mag_r[j] <= tg_r[j][VEC_W-1] ? MAG_W'(-tg_r[j]) : MAG_W'(tg_r[j]);
            neg_r[j] <= tg_r[j][VEC_W-1] ^ det_r[DET_W-1];
          end
        end
      end
      ST_VMAX: begin
        if (mag_r[0] >= mag_r[1] && mag_r[0] >= mag_r[2]) begin
          m_r <= mag_r[0];
        end else if (mag_r[1] >= mag_r[2]) begin
          m_r <= mag_r[1];
        end else begin
          m_r <= mag_r[2];
        end
      end
      ST_SHIFT: begin
        s_r <= '0;
        if (m_r == '0) begin
          degen_r <= 1'b1;
          vsel_r  <= 1'b1;
        end else if (shift_need) begin
          m_r <= m_r >> 1;
          for (int j = 0; j < 3; j++) begin
            mag_r[j] <= mag_r[j] >> 1;
          end
        end
      end
      ST_SQ: begin
        if (st_r != '0) begin
          a2_r[po[1:0]] <= prod[SQ_W-1:0];
          s_r <= s_r + SUM_W'(prod[SQ_W-1:0]);
        end
      end
      ST_SRCH: begin
        if (srch_done) begin
          if (vsel_r) begin
            bq_r[k_r] <= rnd_out;
          end else begin
            tq_r[k_r] <= rnd_out;
          end
          if (k_r == 2'd2) begin
            vsel_r <= 1'b1;
          end
        end
      end
      default: ;
    endcase
  end

  // ---------------- result port ----------------
  assign out_vertex_index = idx_r[oc_r];
  assign out_tangent_x    = tq_r[0];
  assign out_tangent_y    = tq_r[1];
  assign out_tangent_z    = tq_r[2];
  assign out_binormal_x   = bq_r[0];
  assign out_binormal_y   = bq_r[1];
  assign out_binormal_z   = bq_r[2];
  assign out_degenerate   = degen_r;
  assign out_last         = (oc_r == 2'd2);

  // ---------------- checks ----------------
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid))
    else $error("input and result channels open together");

  a_last_frees: assert property (@(posedge clk) disable iff (!rst_n)
    (out_acc && out_last) |=> in_ready)
    else $error("core not ready after last result transaction");

  a_done_in_srch: assert property (@(posedge clk) disable iff (!rst_n)
    srch_done |-> (state_r == ST_SRCH))
    else $error("search finished outside search phase");

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r != 2'd3) && (oc_r != 2'd3 || !out_valid))
    else $error("corner or result count out of range");

endmodule
